/* src/morse_text_decoder_defines.svh */
// ----------------------------------------------------------------------------
// morse_text_decoder_defines
// assertion macros used by the decoder rtl
// ----------------------------------------------------------------------------
`ifndef MORSE_TEXT_DECODER_DEFINES_SVH
`define MORSE_TEXT_DECODER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MTD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define MTD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/mtd_pkg.sv */
// ----------------------------------------------------------------------------
// mtd_pkg
// constants, types and the symbol table of the morse text decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mtd_pkg;

	localparam int MAX_TOKEN = 16;
	localparam int IDX_W     = $clog2(MAX_TOKEN);
	localparam int LEN_W     = $clog2(MAX_TOKEN + 1);
	localparam int PAT_W     = 6;

	localparam logic OP_TEXT  = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic             ovf;
		logic [PAT_W-1:0] pattern;
		logic             only_dd;
		logic [7:0]       first_byte;
	} tok_status_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] ch;
	} lookup_t;

	function automatic logic is_space(input logic [7:0] b);
		return (b inside {[8'h09:8'h0D], 8'h20});
	endfunction

	// key is a marker one above the symbol bits, so length and code are one index
	function automatic lookup_t morse_lookup(input logic [2:0] len, input logic [5:0] code);
		logic [6:0] key;
		lookup_t    r;
		key = (7'd1 << len) | {1'b0, code};
		r.hit = 1'b1;
		case (key)
			7'b0000101: r.ch = "A";
			7'b0011000: r.ch = "B";
			7'b0011010: r.ch = "C";
			7'b0001100: r.ch = "D";
			7'b0000010: r.ch = "E";
			7'b0010010: r.ch = "F";
			7'b0001110: r.ch = "G";
			7'b0010000: r.ch = "H";
			7'b0000100: r.ch = "I";
			7'b0010111: r.ch = "J";
			7'b0001101: r.ch = "K";
			7'b0010100: r.ch = "L";
			7'b0000111: r.ch = "M";
			7'b0000110: r.ch = "N";
			7'b0001111: r.ch = "O";
			7'b0010110: r.ch = "P";
			7'b0011101: r.ch = "Q";
			7'b0001010: r.ch = "R";
			7'b0001000: r.ch = "S";
			7'b0000011: r.ch = "T";
			7'b0001001: r.ch = "U";
			7'b0010001: r.ch = "V";
			7'b0001011: r.ch = "W";
			7'b0011001: r.ch = "X";
			7'b0011011: r.ch = "Y";
			7'b0011100: r.ch = "Z";
			7'b0111111: r.ch = "0";
			7'b0101111: r.ch = "1";
			7'b0100111: r.ch = "2";
			7'b0100011: r.ch = "3";
			7'b0100001: r.ch = "4";
			7'b0100000: r.ch = "5";
			7'b0110000: r.ch = "6";
			7'b0111000: r.ch = "7";
			7'b0111100: r.ch = "8";
			7'b0111110: r.ch = "9";
			7'b1010101: r.ch = ".";
			7'b1110011: r.ch = ",";
			7'b1001100: r.ch = "?";
			7'b1101011: r.ch = "!";
			7'b1100001: r.ch = "-";
			7'b0110010: r.ch = "/";
			7'b1011010: r.ch = "@";
			7'b0110110: r.ch = "(";
			7'b1101101: r.ch = ")";
			7'b0101000: r.ch = "&";
			7'b1111000: r.ch = ":";
			7'b1101010: r.ch = ";";
			7'b0110001: r.ch = "=";
			7'b0101010: r.ch = "+";
			7'b1001101: r.ch = "_";
			7'b1010010: r.ch = 8'h22;
			default: begin
				r.hit = 1'b0;
				r.ch  = 8'h00;
			end
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* src/mtd_text_if.sv */
// ----------------------------------------------------------------------------
// mtd_text_if
// input channel carrying text bytes and end-of-text markers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mtd_text_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] char_in;

	modport source (output valid, output opcode, output char_in, input ready);
	modport sink   (input valid, input opcode, input char_in, output ready);
endinterface

`default_nettype wire

/* src/mtd_result_if.sv */
// ----------------------------------------------------------------------------
// mtd_result_if
// output channel carrying decoded characters
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mtd_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_out;
	logic       last_of_run;
	logic       truncated;

	modport source (output valid, output char_out, output last_of_run, output truncated,
		input ready);
	modport sink   (input valid, input char_out, input last_of_run, input truncated,
		output ready);
endinterface

`default_nettype wire

/* src/mtd_token_buf.sv */
// ----------------------------------------------------------------------------
// mtd_token_buf
// token byte memory with registered read and the running token status
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtd_token_buf
	import mtd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [7:0]       wr_byte,
	input  wire logic             clear,
	input  wire logic [IDX_W-1:0] rd_addr,
	output logic      [7:0]       rd_data_q,
	output tok_status_t           status
);

	logic [7:0]       mem [MAX_TOKEN];
	logic [LEN_W-1:0] len_q;
	logic             ovf_q;
	logic [PAT_W-1:0] pattern_q;
	logic             only_dd_q;
	logic [7:0]       first_byte_q;
	logic             has_room;
	logic             is_dd;

	assign has_room = len_q < LEN_W'(MAX_TOKEN);
	assign is_dd    = (wr_byte == CH_DOT) || (wr_byte == CH_DASH);

	always_ff @(posedge clk) begin
		if (wr_en && has_room) begin
			mem[len_q[IDX_W-1:0]] <= wr_byte;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_en && has_room && (len_q == '0)) begin
			first_byte_q <= wr_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			ovf_q     <= 1'b0;
			pattern_q <= '0;
			only_dd_q <= 1'b1;
		end else if (clear) begin
			len_q     <= '0;
			ovf_q     <= 1'b0;
			pattern_q <= '0;
			only_dd_q <= 1'b1;
		end else if (wr_en) begin
			if (has_room) begin
				if (len_q < LEN_W'(PAT_W)) begin
					pattern_q <= {pattern_q[PAT_W-2:0], wr_byte == CH_DASH};
				end
				if (!is_dd) begin
					only_dd_q <= 1'b0;
				end
				len_q <= len_q + LEN_W'(1);
			end else begin
				ovf_q     <= 1'b1;
				only_dd_q <= 1'b0;
			end
		end
	end

	assign status.len        = len_q;
	assign status.ovf        = ovf_q;
	assign status.pattern    = pattern_q;
	assign status.only_dd    = only_dd_q;
	assign status.first_byte = first_byte_q;

endmodule

`default_nettype wire

/* src/morse_text_decoder.sv */
// ----------------------------------------------------------------------------
// morse_text_decoder
// streaming decoder from dot/dash text tokens to characters
// ----------------------------------------------------------------------------
// channel   dir  payload                            transaction
// text      in   opcode, char_in                    valid && ready
// result    out  char_out, last_of_run, truncated   valid && ready
//
// a text byte is taken only while no token is draining
// a flush drains the token as results, paced by the byte memory read port
// the single output register lets one result wait while the next is read
// reset clears the token length, overflow, pattern and flags; first byte and byte memory are not cleared
// a stalled result holds the drain in place
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "morse_text_decoder_defines.svh"

module morse_text_decoder
	import mtd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	mtd_text_if.sink     text,
	mtd_result_if.source result
);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic [IDX_W-1:0] rd_idx_d;
	logic             single_q;
	logic [7:0]       single_char_q;
	logic             out_valid_q;
	logic [7:0]       char_q;
	logic             last_q;
	logic             trunc_q;

	tok_status_t      tok;
	logic [7:0]       rd_data_q;
	logic             text_acc;
	logic             flush_acc;
	logic             byte_acc;
	logic             fire;
	logic             is_last;
	logic             slash;
	lookup_t          lk;
	logic             hit;
	logic             clear;

	assign text.ready = (state_q == ST_IDLE);
	assign text_acc   = text.valid && text.ready;
	assign flush_acc  = text_acc && ((text.opcode == OP_FLUSH) || is_space(text.char_in));
	assign byte_acc   = text_acc && !flush_acc;

	assign fire    = (state_q == ST_RUN) && (!out_valid_q || result.ready);
	assign is_last = (LEN_W'(rd_idx_q) + LEN_W'(1)) == tok.len;

	assign slash = !tok.ovf && (tok.len == LEN_W'(1)) && (tok.first_byte == CH_SLASH);
	assign lk    = morse_lookup(tok.len[2:0], tok.pattern);
	assign hit   = !tok.ovf && tok.only_dd && (tok.len <= LEN_W'(PAT_W)) && lk.hit;

	assign clear = (flush_acc && (tok.len == '0)) || (fire && (single_q || is_last));

	always_comb begin
		rd_idx_d = rd_idx_q;
		if (state_q == ST_IDLE) begin
			rd_idx_d = '0;
		end else if (fire && !single_q) begin
			rd_idx_d = is_last ? '0 : rd_idx_q + IDX_W'(1);
		end
	end

	mtd_token_buf u_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (byte_acc),
		.wr_byte   (text.char_in),
		.clear     (clear),
		.rd_addr   (rd_idx_d),
		.rd_data_q (rd_data_q),
		.status    (tok)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			rd_idx_q      <= '0;
			single_q      <= 1'b0;
			single_char_q <= 8'h00;
			out_valid_q   <= 1'b0;
			char_q        <= 8'h00;
			last_q        <= 1'b0;
			trunc_q       <= 1'b0;
		end else begin
			rd_idx_q <= rd_idx_d;
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (flush_acc && (tok.len != '0)) begin
						single_q      <= slash || hit;
						single_char_q <= slash ? CH_SPACE : lk.ch;
						state_q       <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (fire) begin
						if (single_q) begin
							char_q  <= single_char_q;
							last_q  <= 1'b1;
							trunc_q <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							char_q  <= rd_data_q;
							last_q  <= is_last;
							trunc_q <= is_last && tok.ovf;
							if (is_last) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid       = out_valid_q;
	assign result.char_out    = char_q;
	assign result.last_of_run = last_q;
	assign result.truncated   = trunc_q;

	`MTD_ASSERT_NEXT(a_clear_after_last, fire && (single_q || is_last), tok.len == '0, "token not cleared after last result")
	`MTD_ASSERT_NOW(a_run_has_token, state_q == ST_RUN, tok.len != '0, "draining with empty token")
	`MTD_ASSERT_NOW(a_idx_in_range, (state_q == ST_RUN) && !single_q, LEN_W'(rd_idx_q) < tok.len, "read index past token end")

endmodule

`default_nettype wire
